// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker of the cipher block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/kwsc_pkg.sv =====
// Types, constants and helper functions of the keyword substitution cipher.
`default_nettype none
package kwsc_pkg;

    localparam int LETTERS = 26;
    localparam int IDX_W   = 5;
    localparam logic [7:0] BASE_UPPER = 8'h41;
    localparam logic [7:0] BASE_LOWER = 8'h61;

    typedef enum logic [1:0] {
        ACT_RESTART = 2'd0,
        ACT_KEYWORD = 2'd1,
        ACT_FINISH  = 2'd2,
        ACT_TEXT    = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] char_in;
    } t_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       not_ready;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_letter;

    // One placement: position pos of the alphabet receives letter.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] letter;
    } t_place;

    // Folds an ASCII letter of either case to its index 0..25.
    function automatic t_letter letter_of(logic [7:0] c);
        t_letter    r;
        logic [7:0] d;
        r.valid = 1'b0;
        r.idx   = '0;
        d       = '0;
        if (c >= BASE_UPPER && c < BASE_UPPER + 8'(LETTERS)) begin
            d       = c - BASE_UPPER;
            r.valid = 1'b1;
            r.idx   = d[IDX_W-1:0];
        end else if (c >= BASE_LOWER && c < BASE_LOWER + 8'(LETTERS)) begin
            d       = c - BASE_LOWER;
            r.valid = 1'b1;
            r.idx   = d[IDX_W-1:0];
        end
        return r;
    endfunction

    // Turns a stored index into its upper-case letter, reduced modulo 26.
    function automatic logic [7:0] upper_of(logic [IDX_W-1:0] m);
        logic [IDX_W-1:0] v;
        v = (m >= IDX_W'(LETTERS)) ? m - IDX_W'(LETTERS) : m;
        return BASE_UPPER + {{(8 - IDX_W){1'b0}}, v};
    endfunction

endpackage
`default_nettype wire

// ===== sv/keyword_substitution_cipher.sv =====
// Top level of the keyword substitution cipher: command port, tables and result stage.
`default_nettype none
// Usage:
// A command beat is taken at a rising edge with start high and busy low. Its
// action selects restart, keyword character, finish or text character.
// Keyword characters are placed as they are taken; repeated letters and
// non-letters are dropped. A finish that finds the alphabet unfinished walks
// all 26 letters, one per cycle, appending those not yet used; busy is high
// during the walk and no command is taken meanwhile.
// A text character gives one result beat on o_result, marked by o_strobe,
// in the cycle after it was taken; a looked-up letter comes from the registered
// read of the forward or inverse table memory. Text is taken every cycle, so
// the sustained rate is one character per clock outside a finish walk.
// The receiver cannot stall: each result is shown for one cycle only.
// Before a finish, text passes through unchanged with not_ready set.
// i_cfg_we writes the decrypt mode bit; write it only while no beat is in
// flight. Synchronous reset clears the mode, the used-letter flags, the fill
// position and the ready flag; the tables themselves are not cleared, since
// a finish rewrites every entry before any lookup.
module keyword_substitution_cipher (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire kwsc_pkg::t_item   i_item,
    output logic                   o_strobe,
    output kwsc_pkg::t_result      o_result,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data
);
    import kwsc_pkg::*;

    logic             accept;
    logic             text_acc;
    logic             rd_en;
    t_letter          letter;
    t_place           place;
    logic             ready;
    logic [IDX_W-1:0] fwd_q;
    logic [IDX_W-1:0] inv_q;

    logic             r_mode;
    logic             r_strobe;
    logic             r_pass;
    logic             r_not_ready;
    logic             r_sel_inv;
    logic [7:0]       r_char;

    assign accept   = start && !busy;
    assign letter   = letter_of(i_item.char_in);
    assign text_acc = accept && (i_item.action == ACT_TEXT);
    // Only a letter after the alphabet is finished needs a table lookup.
    assign rd_en    = text_acc && ready && letter.valid;

    // The decrypt mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    kwsc_builder u_builder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_item.action),
        .i_letter (letter),
        .o_place  (place),
        .o_ready  (ready),
        .o_busy   (busy)
    );

    // Forward table: alphabet position to letter.
    kwsc_ram #(
        .DEPTH (LETTERS),
        .WIDTH (IDX_W)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (place.we),
        .i_waddr (place.pos),
        .i_wdata (place.letter),
        .i_re    (rd_en),
        .i_raddr (letter.idx),
        .o_rdata (fwd_q)
    );

    // Inverse table: letter to alphabet position, written in the same cycle.
    kwsc_ram #(
        .DEPTH (LETTERS),
        .WIDTH (IDX_W)
    ) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (place.we),
        .i_waddr (place.letter),
        .i_wdata (place.pos),
        .i_re    (rd_en),
        .i_raddr (letter.idx),
        .o_rdata (inv_q)
    );

    // Result stage. The strobe is control state; the rest is payload that
    // travels beside the memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= text_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (text_acc) begin
            r_pass      <= !ready || !letter.valid;
            r_not_ready <= !ready;
            r_sel_inv   <= r_mode;
            r_char      <= i_item.char_in;
        end
    end

    assign o_strobe           = r_strobe;
    assign o_result.char_out  = r_pass ? r_char : upper_of(r_sel_inv ? inv_q : fwd_q);
    assign o_result.not_ready = r_not_ready;

endmodule
`default_nettype wire

// ===== sv/kwsc_ram.sv =====
// Simple dual-port table memory with one registered read port.
`default_nettype none
module kwsc_ram #(
    parameter int  DEPTH = kwsc_pkg::LETTERS,
    parameter int  WIDTH = kwsc_pkg::IDX_W,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/kwsc_builder.sv =====
// Alphabet builder: used letters, fill position and the finish walk.
`default_nettype none
module kwsc_builder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire kwsc_pkg::t_action i_action,
    input  wire kwsc_pkg::t_letter i_letter,
    output kwsc_pkg::t_place       o_place,
    output logic                   o_ready,
    output logic                   o_busy
);
    import kwsc_pkg::*;

    typedef enum logic {S_IDLE, S_WALK} t_state;

    t_state             r_state, n_state;
    logic [LETTERS-1:0] r_used, n_used;
    logic [IDX_W-1:0]   r_fill, n_fill;
    logic [IDX_W-1:0]   r_walk, n_walk;
    logic               r_ready, n_ready;

    logic               cand_valid;
    logic [IDX_W-1:0]   cand_idx;
    logic               place_we;

    // The walk offers each letter in turn; otherwise a keyword letter is offered.
    always_comb begin
        cand_valid = 1'b0;
        cand_idx   = i_letter.idx;
        if (r_state == S_WALK) begin
            cand_valid = 1'b1;
            cand_idx   = r_walk;
        end else if (i_accept && i_action == ACT_KEYWORD && !r_ready && i_letter.valid) begin
            cand_valid = 1'b1;
        end
    end

    assign place_we = cand_valid && !r_used[cand_idx] && (r_fill < IDX_W'(LETTERS));

    always_comb begin
        n_state = r_state;
        n_used  = r_used;
        n_fill  = r_fill;
        n_walk  = r_walk;
        n_ready = r_ready;
        if (place_we) begin
            n_used[cand_idx] = 1'b1;
            n_fill           = r_fill + 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    case (i_action)
                        ACT_RESTART: begin
                            n_used  = '0;
                            n_fill  = '0;
                            n_ready = 1'b0;
                        end
                        ACT_FINISH: begin
                            if (!r_ready) begin
                                n_state = S_WALK;
                                n_walk  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (r_walk == IDX_W'(LETTERS - 1)) begin
                    n_state = S_IDLE;
                    n_ready = 1'b1;
                end else begin
                    n_walk = r_walk + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_fill  <= '0;
            r_walk  <= '0;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_fill  <= n_fill;
            r_walk  <= n_walk;
            r_ready <= n_ready;
        end
    end

    assign o_place.we     = place_we;
    assign o_place.pos    = r_fill;
    assign o_place.letter = cand_idx;
    assign o_ready        = r_ready;
    assign o_busy         = (r_state == S_WALK);

endmodule
`default_nettype wire

// ===== sv/kwsc_checker.sv =====
// Port-level checker of the cipher block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module kwsc_assertions (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire kwsc_pkg::t_item   i_item,
    input  wire logic              o_strobe,
    input  wire kwsc_pkg::t_result o_result
);
    import kwsc_pkg::*;

    logic    text_acc;
    logic    fin_acc;
    t_letter letter;

    assign text_acc = start && !busy && (i_item.action == ACT_TEXT);
    assign fin_acc  = start && !busy && (i_item.action == ACT_FINISH);
    assign letter   = letter_of(i_item.char_in);

    `KW_ASSERT_NXT(a_text_gives_result, i_clk, i_rst_n, text_acc, o_strobe, "text beat gave no result")
    `KW_ASSERT_IMP(a_result_has_cause, i_clk, i_rst_n, o_strobe, $past(text_acc), "result beat without a text beat")
    `KW_ASSERT_IMP(a_busy_from_finish, i_clk, i_rst_n, $rose(busy), $past(fin_acc), "busy rose without a finish beat")
    `KW_ASSERT_NXT(a_nonletter_passes, i_clk, i_rst_n, text_acc && !letter.valid, o_result.char_out == $past(i_item.char_in), "non-letter byte was altered")
    `KW_ASSERT_IMP(a_not_ready_passes, i_clk, i_rst_n, o_strobe && o_result.not_ready, o_result.char_out == $past(i_item.char_in), "text before finish was altered")

endmodule

bind keyword_substitution_cipher kwsc_assertions u_kwsc_assertions (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
`default_nettype wire

// ===== tb/kwsc_checker.sv =====
// Checker for the keyword substitution cipher: tracks the alphabet and compares each result beat.
module kwsc_checker
    import kwsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_strobe,
    input  t_result i_result,
    input  logic    i_cfg_we,
    input  logic    i_cfg_data,
    output int      o_pending,
    output int      o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ALPHA_LEN = 26;
    localparam logic [7:0] CH_UPPER  = 8'h41;
    localparam logic [7:0] CH_LOWER  = 8'h61;

    // Shadow copy of the keyed alphabet and its inverse.
    logic [4:0]  key_order [ALPHA_LEN] = '{default: '0};
    logic [4:0]  key_slot  [ALPHA_LEN] = '{default: '0};
    logic [25:0] taken     = '0;
    int          placed    = 0;
    logic        keyed     = 1'b0;
    logic        deciphering = 1'b0;

    t_result     cipher_chars [$];
    int          fail_cnt     = 0;
    int          result_no    = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic int alpha_pos(logic [7:0] c);
        if (c >= CH_UPPER && c < CH_UPPER + 8'(ALPHA_LEN)) return int'(c - CH_UPPER);
        if (c >= CH_LOWER && c < CH_LOWER + 8'(ALPHA_LEN)) return int'(c - CH_LOWER);
        return -1;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_cnt < 40) $display("[%0t] cipher check: %s", $realtime, msg);
        fail_cnt++;
    endtask

    task automatic append_letter(int k);
        if (!taken[k] && placed < ALPHA_LEN) begin
            key_order[placed] = 5'(k);
            key_slot[k]       = 5'(placed);
            taken[k]          = 1'b1;
            placed++;
        end
    endtask

    // Applies one accepted command beat and queues the character it must produce.
    task automatic advance_cipher(t_item it);
        int      k;
        int      m;
        t_result r;
        k = alpha_pos(it.char_in);
        case (it.action)
            ACT_RESTART: begin
                taken  = '0;
                placed = 0;
                keyed  = 1'b0;
            end
            ACT_KEYWORD: begin
                if (!keyed && k >= 0) append_letter(k);
            end
            ACT_FINISH: begin
                if (!keyed) begin
                    for (int p = 0; p < ALPHA_LEN; p++) append_letter(p);
                    keyed = 1'b1;
                end
            end
            ACT_TEXT: begin
                r.not_ready = !keyed;
                r.char_out  = it.char_in;
                if (keyed && k >= 0) begin
                    m = deciphering ? int'(key_slot[k]) : int'(key_order[k]);
                    r.char_out = 8'(int'(CH_UPPER) + m % ALPHA_LEN);
                end
                cipher_chars.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            taken       = '0;
            placed      = 0;
            keyed       = 1'b0;
            deciphering = 1'b0;
        end else begin
            if (i_strobe) begin
                if (cipher_chars.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with none expected: %h",
                                              result_no, i_result));
                end else begin
                    want = cipher_chars.pop_front();
                    if (i_result.char_out !== want.char_out)
                        report_mismatch($sformatf("result %0d char_out %h, expected %h",
                                                  result_no, i_result.char_out,
                                                  want.char_out));
                    if (i_result.not_ready !== want.not_ready)
                        report_mismatch($sformatf("result %0d not_ready %b, expected %b",
                                                  result_no, i_result.not_ready,
                                                  want.not_ready));
                end
                result_no++;
            end
            if (i_cfg_we) deciphering = i_cfg_data;
            if (i_start && !i_busy) advance_cipher(i_item);
        end
        o_pending    <= cipher_chars.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the keyword substitution cipher: clock, reset, command stimulus and verdict.
module tb;
    import kwsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling: even if every beat were a finish walk with the sender
    // idling half the time, the run stays far below this.
    localparam int LIMIT_CYCLES = 400_000;
    // Long enough to cover a finish walk and the result stage behind it.
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_BEATS  = 225;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    start    = 1'b0;
    logic    busy;
    t_item   cmd      = '{action: ACT_RESTART, char_in: 8'h00};
    logic    strobe;
    t_result res;
    logic    cfg_we   = 1'b0;
    logic    cfg_data = 1'b0;

    int      pending;
    int      fail_count;
    int      idle_pct   = 0;
    int      beat_count = 0;
    int      cycle_count = 0;

    always #6 clk = ~clk;

    keyword_substitution_cipher u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (cmd),
        .o_strobe   (strobe),
        .o_result   (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // The checker sits beside the block, sees the same pins and does all the
    // predicting; this module only drives and decides.
    kwsc_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (cmd),
        .i_strobe     (strobe),
        .i_result     (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Watchdog. A hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("** keyword_substitution_cipher: FAILED **");
            $finish;
        end
    end

    // Offers one command beat and returns at the edge that takes it. The sender
    // may first idle for a few cycles. Start is only raised here and is left
    // high on return, so back-to-back beats never lower and raise it in one step.
    // Busy is read right after the edge, which still shows its value from
    // before the edge, the value the block itself used to decide acceptance.
    task automatic send_beat(t_action act, logic [7:0] ch);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{action: act, char_in: ch};
        do @(posedge clk); while (busy);
        beat_count++;
    endtask

    // Drops start and waits until the block has nothing left in flight: long
    // enough for a finish walk that may still be running, then until every
    // queued character has come out and busy is low.
    task automatic settle();
        start <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
    endtask

    // The mode bit is only changed while the block is idle.
    task automatic set_decrypt(logic dec);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= dec;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Character mix: mostly letters of both cases, some bytes right next to the
    // letter ranges, and some bytes from anywhere including the top half.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'h41 + 8'($urandom_range(0, 25));
            4, 5, 6:    return 8'h61 + 8'($urandom_range(0, 25));
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 8'h40;
                    1:       return 8'h5B;
                    2:       return 8'h60;
                    default: return 8'h7B;
                endcase
            end
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Keys the alphabet with all 26 letters in shuffled order and mixed case,
    // so the fill position reaches its end before the finish arrives.
    task automatic send_full_keyword();
        int perm [26];
        int j;
        int t;
        for (int i = 0; i < 26; i++) perm[i] = i;
        for (int i = 25; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < 26; i++)
            send_beat(ACT_KEYWORD, ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(perm[i]));
    endtask

    // One random phase. Most of it is complete sessions: restart, a keyword,
    // finish, then a run of text with the odd stray command mixed in. The
    // remainder is loose noise beats and sessions that never finish, so that
    // text also meets an unfinished alphabet.
    task automatic run_phase(int pct);
        int goal;
        int key_len;
        int text_len;
        idle_pct = pct;
        goal     = beat_count + PHASE_BEATS;
        while (beat_count < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(t_action'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                send_beat(ACT_RESTART, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 5) == 0) begin
                    send_full_keyword();
                end else begin
                    key_len = $urandom_range(0, 12);
                    for (int i = 0; i < key_len; i++) send_beat(ACT_KEYWORD, pick_char());
                end
                if ($urandom_range(0, 7) != 0)
                    send_beat(ACT_FINISH, 8'($urandom_range(0, 255)));
                text_len = $urandom_range(4, 40);
                for (int i = 0; i < text_len; i++) begin
                    case ($urandom_range(0, 29))
                        0:       send_beat(ACT_KEYWORD, pick_char());
                        1:       send_beat(ACT_FINISH, pick_char());
                        default: send_beat(ACT_TEXT, pick_char());
                    endcase
                end
            end
        end
    endtask

    initial begin
        // Synchronous reset held low from time zero, then released for good.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening in encipher mode.
        // Text before any finish must pass through with not_ready set.
        send_beat(ACT_TEXT, 8'h61);
        send_beat(ACT_TEXT, 8'hFF);
        // Keyword "zZa", non-letters and M: the repeat in the other case and
        // the bytes just outside the letter ranges are dropped.
        send_beat(ACT_KEYWORD, 8'h7A);
        send_beat(ACT_KEYWORD, 8'h5A);
        send_beat(ACT_KEYWORD, 8'h61);
        send_beat(ACT_KEYWORD, 8'h40);
        send_beat(ACT_KEYWORD, 8'h00);
        send_beat(ACT_KEYWORD, 8'h5B);
        send_beat(ACT_KEYWORD, 8'h4D);
        send_beat(ACT_FINISH, 8'hFF);
        // After the finish a keyword letter and a second finish are ignored.
        send_beat(ACT_KEYWORD, 8'h42);
        send_beat(ACT_FINISH, 8'h00);
        // Lookups at the low end of the upper case and the high end of the lower case, boundary bytes and a high byte.
        send_beat(ACT_TEXT, 8'h41);
        send_beat(ACT_TEXT, 8'h7A);
        send_beat(ACT_TEXT, 8'h60);
        send_beat(ACT_TEXT, 8'h7B);
        send_beat(ACT_TEXT, 8'h80);
        send_beat(ACT_TEXT, 8'h00);
        send_beat(ACT_TEXT, 8'h6D);
        // Restart drops readiness again; an empty keyword then gives the
        // plain A to Z alphabet.
        send_beat(ACT_RESTART, 8'h5A);
        send_beat(ACT_TEXT, 8'h51);
        send_beat(ACT_FINISH, 8'h41);
        send_beat(ACT_TEXT, 8'h59);
        // The same alphabet read backwards through the inverse table.
        set_decrypt(1'b1);
        send_beat(ACT_TEXT, 8'h43);
        send_beat(ACT_TEXT, 8'h79);

        // Random part: sender idling at 10, then 46, then 0 percent, each with
        // both modes. Each mode write waits for the block to drain.
        run_phase(10);
        set_decrypt(1'b0);
        run_phase(10);
        set_decrypt(1'b1);
        run_phase(46);
        set_decrypt(1'b0);
        run_phase(46);
        set_decrypt(1'b1);
        run_phase(0);
        set_decrypt(1'b0);
        run_phase(0);

        // Let every result drain, then give the checker's counters time to update.
        settle();
        repeat (4) @(posedge clk);

        if (pending != 0)
            $display("%0d expected characters never came out", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("** keyword_substitution_cipher: PASSED **");
        end else begin
            $display("** keyword_substitution_cipher: FAILED **");
        end
        $finish;
    end

endmodule

// ===== keyword_substitution_cipher.f =====
+incdir+sv
sv/kwsc_pkg.sv
sv/kwsc_ram.sv
sv/kwsc_builder.sv
sv/keyword_substitution_cipher.sv
sv/kwsc_checker.sv
tb/kwsc_checker.sv
tb/tb.sv
